FILE: hdl/swfr_pkg.sv
package swfr_pkg;

  localparam int SeqCount = 32;
  localparam int Window   = 4;
  localparam int SeqW     = $clog2(SeqCount);
  localparam int LenW     = 6;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NACK = 2'd2
  } reply_e;

  typedef struct packed {
    logic            header_ok;
    logic [1:0]      frame_kind;
    logic [4:0]      frame_seq;
    logic            crc_ok;
    logic [LenW-1:0] payload_len;
  } frame_t;

  typedef struct packed {
    logic [1:0]      reply_kind;
    logic [4:0]      reply_seq;
    logic            write_payload;
    logic [LenW-1:0] write_len;
    logic            transfer_done;
    logic            transfer_ok;
  } reply_t;

  // modular add of a small offset to a sequence number
  function automatic logic [SeqW-1:0] seq_add(input logic [SeqW-1:0] base,
                                              input logic [SeqW:0]   offs);
    logic [SeqW:0] sum;
    sum = {1'b0, base} + offs;
    if (sum >= (SeqW+1)'(SeqCount)) begin
      sum = sum - (SeqW+1)'(SeqCount);
    end
    return sum[SeqW-1:0];
  endfunction

  function automatic logic [SeqW-1:0] window_end(input logic [SeqW-1:0] first);
    return seq_add(first, (SeqW+1)'(Window - 1));
  endfunction

endpackage

FILE: hdl/swfr_if.sv
interface swfr_frame_if;
  import swfr_pkg::*;

  logic   valid;
  logic   ready;
  frame_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface swfr_reply_if;
  import swfr_pkg::*;

  logic   valid;
  logic   ready;
  reply_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/swfr_core.sv
module swfr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  swfr_pkg::frame_t frame_i,
  output swfr_pkg::reply_t reply_o
);
  import swfr_pkg::*;

  typedef enum logic [1:0] {
    MODE_RX        = 2'd0,
    MODE_DRAIN_CRC = 2'd1,
    MODE_DRAIN_SEQ = 2'd2
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [SeqW-1:0]      exp_q, exp_d;
  logic [SeqW-1:0]      first_q, first_d;
  logic [SeqW-1:0]      last_q, last_d;
  logic [SeqCount-1:0]  mark_q, mark_d;

  always_comb begin
    mode_d  = mode_q;
    exp_d   = exp_q;
    first_d = first_q;
    last_d  = last_q;
    mark_d  = mark_q;
    reply_o = '0;

    unique case (mode_q)
      MODE_DRAIN_CRC, MODE_DRAIN_SEQ: begin
        if (frame_i.frame_seq == last_q || frame_i.frame_kind == KIND_END) begin
          if (mode_q == MODE_DRAIN_CRC) begin
            mark_d              = '0;
            first_d             = exp_q;
            last_d              = window_end(exp_q);
            reply_o.reply_seq   = exp_q;
          end else begin
            exp_d               = first_q;
            reply_o.reply_seq   = first_q;
          end
          reply_o.reply_kind = REPLY_NACK;
          mode_d             = MODE_RX;
        end
      end
      default: begin
        if (frame_i.header_ok) begin
          priority if (frame_i.frame_kind == KIND_ERR) begin
            reply_o.reply_kind    = REPLY_ACK;
            reply_o.reply_seq     = frame_i.frame_seq;
            reply_o.transfer_done = 1'b1;
            mode_d  = MODE_RX;
            exp_d   = '0;
            first_d = '0;
            last_d  = window_end('0);
            mark_d  = '0;
          end else if (!frame_i.crc_ok) begin
            mode_d = MODE_DRAIN_CRC;
          end else if (frame_i.frame_seq != exp_q) begin
            mode_d = MODE_DRAIN_SEQ;
          end else if (frame_i.frame_kind == KIND_END) begin
            reply_o.reply_kind    = REPLY_ACK;
            reply_o.reply_seq     = frame_i.frame_seq;
            reply_o.transfer_done = 1'b1;
            reply_o.transfer_ok   = 1'b1;
            mode_d  = MODE_RX;
            exp_d   = '0;
            first_d = '0;
            last_d  = window_end('0);
            mark_d  = '0;
          end else begin
            if (!mark_q[frame_i.frame_seq]) begin
              mark_d[frame_i.frame_seq] = 1'b1;
              reply_o.write_payload     = 1'b1;
              reply_o.write_len         = frame_i.payload_len;
            end
            if (frame_i.frame_seq == last_q) begin
              reply_o.reply_kind = REPLY_ACK;
              reply_o.reply_seq  = last_q;
              mark_d             = '0;
              first_d            = seq_add(exp_q, (SeqW+1)'(1));
              last_d             = window_end(first_d);
            end
            exp_d = seq_add(exp_q, (SeqW+1)'(1));
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RX;
      exp_q   <= '0;
      first_q <= '0;
      last_q  <= window_end('0);
      mark_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      exp_q   <= exp_d;
      first_q <= first_d;
      last_q  <= last_d;
      mark_q  <= mark_d;
    end
  end

endmodule

FILE: hdl/sliding_window_frame_receiver.sv
// pipeline: a frame beat is held in the input register, its reply in the
// reply register; throughput: one frame per cycle unless reply_o stalls;
// the per-frame state update is one combinational step between the two
// reset: mode returns to receiving, expected sequence and window start to 0,
// window end to window-1, written marks and both valid flags cleared
module sliding_window_frame_receiver (
  input  logic         clk_i,
  input  logic         rst_ni,
  swfr_frame_if.sink   frame_i,
  swfr_reply_if.source reply_o
);
  import swfr_pkg::*;

  logic   in_vld_q;
  frame_t in_q;
  logic   out_vld_q;
  reply_t out_q;
  reply_t reply;
  logic   advance;

  assign advance       = !out_vld_q || reply_o.ready;
  assign frame_i.ready = !in_vld_q || advance;

  swfr_core u_core (
    .clk_i,
    .rst_ni,
    .step_i  (in_vld_q && advance),
    .frame_i (in_q),
    .reply_o (reply)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (frame_i.ready) begin
        in_vld_q <= frame_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.ready && frame_i.valid) begin
      in_q <= frame_i.payload;
    end
    if (advance && in_vld_q) begin
      out_q <= reply;
    end
  end

  assign reply_o.valid   = out_vld_q;
  assign reply_o.payload = out_q;

endmodule

FILE: hdl/swfr_checker.sv
module swfr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             frame_ready_i,
  input logic             reply_valid_i,
  input logic             reply_ready_i,
  input swfr_pkg::reply_t reply_i
);
  import swfr_pkg::*;

  // a stalled reply beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && !reply_ready_i |=> reply_valid_i && $stable(reply_i))
    else $error("reply beat changed while stalled");

  // no stall on the reply side means frames are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_ready_i |-> frame_ready_i)
    else $error("frame side stalled without back pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && reply_i.transfer_done |-> reply_i.reply_kind == REPLY_ACK)
    else $error("transfer end without ack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && reply_i.transfer_ok |-> reply_i.transfer_done)
    else $error("transfer ok without done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && reply_i.write_payload |-> !reply_i.transfer_done &&
      reply_i.reply_kind != REPLY_NACK)
    else $error("payload write on ending or nacked frame");

endmodule

bind sliding_window_frame_receiver swfr_checker u_swfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .frame_ready_i (frame_i.ready),
  .reply_valid_i (reply_o.valid),
  .reply_ready_i (reply_o.ready),
  .reply_i       (reply_o.payload)
);

FILE: verif/swfr_reply_checker.sv
module swfr_reply_checker
  import swfr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  swfr_frame_if  frame_i,
  swfr_reply_if  reply_i,
  output int     errors_o,
  output int     pending_o,
  output int     frames_o,
  output int     acks_o,
  output int     nacks_o,
  output int     writes_o,
  output int     transfers_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ST_RECV      = 2'd0;
  localparam logic [1:0] ST_DRAIN_CRC = 2'd1;
  localparam logic [1:0] ST_DRAIN_SEQ = 2'd2;
  localparam logic [SeqW-1:0] WIN_SPAN = SeqW'(Window - 1);

  logic [1:0]      rx_state;
  logic [SeqW-1:0] next_seq;
  logic [SeqW-1:0] win_lo;
  logic [SeqW-1:0] win_hi;
  logic [31:0]     seen_map;

  reply_t reply_q[$];
  int fail_count;
  int n_frames, n_replies, n_acks, n_nacks, n_writes, n_transfers;

  function automatic void restart_link();
    rx_state = ST_RECV;
    next_seq = '0;
    win_lo   = '0;
    win_hi   = WIN_SPAN;
    seen_map = '0;
  endfunction

  function automatic reply_t predict_reply(input frame_t f);
    reply_t r;
    r = '0;
    if (rx_state == ST_DRAIN_CRC || rx_state == ST_DRAIN_SEQ) begin
      if (f.frame_seq == win_hi || f.frame_kind == KIND_END) begin
        r.reply_kind = REPLY_NACK;
        if (rx_state == ST_DRAIN_CRC) begin
          seen_map    = '0;
          win_lo      = next_seq;
          win_hi      = next_seq + WIN_SPAN;
          r.reply_seq = next_seq;
        end else begin
          next_seq    = win_lo;
          r.reply_seq = win_lo;
        end
        rx_state = ST_RECV;
      end
    end else if (f.header_ok) begin
      if (f.frame_kind == KIND_ERR) begin
        r.reply_kind    = REPLY_ACK;
        r.reply_seq     = f.frame_seq;
        r.transfer_done = 1'b1;
        restart_link();
      end else if (!f.crc_ok) begin
        rx_state = ST_DRAIN_CRC;
      end else if (f.frame_seq != next_seq) begin
        rx_state = ST_DRAIN_SEQ;
      end else if (f.frame_kind == KIND_END) begin
        r.reply_kind    = REPLY_ACK;
        r.reply_seq     = f.frame_seq;
        r.transfer_done = 1'b1;
        r.transfer_ok   = 1'b1;
        restart_link();
      end else begin
        // payload goes out only the first time this window sees the sequence
        if (!seen_map[f.frame_seq]) begin
          seen_map[f.frame_seq] = 1'b1;
          r.write_payload = 1'b1;
          r.write_len     = f.payload_len;
        end
        if (f.frame_seq == win_hi) begin
          r.reply_kind = REPLY_ACK;
          r.reply_seq  = win_hi;
          seen_map     = '0;
          win_lo       = next_seq + 1'b1;
          win_hi       = next_seq + 1'b1 + WIN_SPAN;
        end
        next_seq = next_seq + 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns, reply beat %0d: %s", $time, n_replies, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      restart_link();
      reply_q.delete();
      fail_count  = 0;
      n_frames    = 0;
      n_replies   = 0;
      n_acks      = 0;
      n_nacks     = 0;
      n_writes    = 0;
      n_transfers = 0;
    end else begin
      if (frame_i.valid && frame_i.ready) begin
        reply_q.insert(reply_q.size(), predict_reply(frame_i.payload));
        n_frames++;
      end
      if (reply_i.valid && reply_i.ready) begin
        got = reply_i.payload;
        if (reply_q.size() == 0) begin
          report_mismatch("reply beat with no frame outstanding");
        end else begin
          want = reply_q.pop_front();
          check_field("reply_kind", 8'(got.reply_kind), 8'(want.reply_kind));
          check_field("reply_seq", 8'(got.reply_seq), 8'(want.reply_seq));
          check_field("write_payload", 8'(got.write_payload),
                      8'(want.write_payload));
          check_field("write_len", 8'(got.write_len), 8'(want.write_len));
          check_field("transfer_done", 8'(got.transfer_done),
                      8'(want.transfer_done));
          check_field("transfer_ok", 8'(got.transfer_ok), 8'(want.transfer_ok));
          if (want.reply_kind == REPLY_ACK) n_acks++;
          if (want.reply_kind == REPLY_NACK) n_nacks++;
          if (want.write_payload) n_writes++;
          if (want.transfer_done) n_transfers++;
        end
        n_replies++;
      end
    end
    errors_o    <= fail_count;
    pending_o   <= reply_q.size();
    frames_o    <= n_frames;
    acks_o      <= n_acks;
    nacks_o     <= n_nacks;
    writes_o    <= n_writes;
    transfers_o <= n_transfers;
  end

endmodule

FILE: verif/sliding_window_frame_receiver_tb.sv
module sliding_window_frame_receiver_tb;
  import swfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_ALT_DATA = 2'd3;
  localparam logic [SeqW-1:0] WIN_SPAN = SeqW'(Window - 1);
  localparam int RANDOM_BEATS = 1050;

  logic clk_i;
  logic rst_ni;

  swfr_frame_if frame_if ();
  swfr_reply_if reply_if ();

  int errors, pending, frames, acks, nacks, writes, transfers;

  logic [SeqW-1:0] tx_next;
  logic [SeqW-1:0] tx_base;
  int  beats_sent;
  int  noise_beats;
  bit  steady_phase;

  sliding_window_frame_receiver uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_if),
    .reply_o (reply_if)
  );

  swfr_reply_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_if),
    .reply_i     (reply_if),
    .errors_o    (errors),
    .pending_o   (pending),
    .frames_o    (frames),
    .acks_o      (acks),
    .nacks_o     (nacks),
    .writes_o    (writes),
    .transfers_o (transfers)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    reply_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      reply_if.ready <= steady_phase || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic frame_t mk_frame(input logic hdr, input logic [1:0] kind,
                                      input logic [SeqW-1:0] seq, input logic crc,
                                      input logic [LenW-1:0] len);
    frame_t f;
    f.header_ok   = hdr;
    f.frame_kind  = kind;
    f.frame_seq   = seq;
    f.crc_ok      = crc;
    f.payload_len = len;
    return f;
  endfunction

  function automatic frame_t rand_frame();
    return mk_frame(1'($urandom_range(1)), 2'($urandom_range(3)),
                    SeqW'($urandom_range(SeqCount - 1)), 1'($urandom_range(1)),
                    LenW'($urandom_range(63)));
  endfunction

  task automatic send_frame(input frame_t f);
    while (!steady_phase && $urandom_range(99) < 9) begin
      frame_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    frame_if.valid   <= 1'b1;
    frame_if.payload <= f;
    @(posedge clk_i);
    while (!frame_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_in_order_data();
    frame_t f;
    f = rand_frame();
    f.header_ok  = 1'b1;
    f.crc_ok     = 1'b1;
    f.frame_seq  = tx_next;
    f.frame_kind = ($urandom_range(3) == 0) ? KIND_ALT_DATA : KIND_DATA;
    send_frame(f);
    if (tx_next == tx_base + WIN_SPAN) tx_base = tx_next + 1'b1;
    tx_next = tx_next + 1'b1;
  endtask

  // swallowed beats, then one that hits the window end or carries end kind
  task automatic run_drain(input bit after_crc);
    frame_t f;
    logic [SeqW-1:0] win_end;
    int n;
    win_end = tx_base + WIN_SPAN;
    n = $urandom_range(4);
    repeat (n) begin
      f = rand_frame();
      if (f.frame_seq == win_end) f.frame_seq = win_end + 1'b1;
      if (f.frame_kind == KIND_END) f.frame_kind = KIND_DATA;
      send_frame(f);
    end
    f = rand_frame();
    if ($urandom_range(1)) begin
      f.frame_kind = KIND_END;
    end else begin
      f.frame_seq = win_end;
      if (f.frame_kind == KIND_END) f.frame_kind = KIND_ERR;
    end
    send_frame(f);
    if (after_crc) begin
      tx_base = tx_next;
    end else begin
      tx_next = tx_base;
    end
  endtask

  initial begin
    frame_t f;
    int pick;
    rst_ni           <= 1'b0;
    frame_if.valid   <= 1'b0;
    frame_if.payload <= '0;
    tx_next      = '0;
    tx_base      = '0;
    beats_sent   = 0;
    noise_beats  = 0;
    steady_phase = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad headers are dropped
    send_frame(mk_frame(1'b0, KIND_ERR, 5'd31, 1'b1, 6'd63));
    send_frame(mk_frame(1'b0, KIND_END, 5'd0, 1'b0, 6'd0));
    // first window in order, ack at its end
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd0, 1'b1, 6'd63));
    send_frame(mk_frame(1'b1, KIND_ALT_DATA, 5'd1, 1'b1, 6'd0));
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd2, 1'b1, 6'd42));
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd3, 1'b1, 6'd21));
    // sequence fault on the window end frame, drain ignores header, crc, error
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd4, 1'b1, 6'd7));
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd7, 1'b1, 6'd9));
    send_frame(mk_frame(1'b0, KIND_ERR, 5'd0, 1'b0, 6'd5));
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd7, 1'b0, 6'd1));
    // resent frame already written in this window
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd4, 1'b1, 6'd33));
    // crc fault on an end frame, drain ended by an end frame
    send_frame(mk_frame(1'b1, KIND_END, 5'd5, 1'b0, 6'd12));
    send_frame(mk_frame(1'b1, KIND_END, 5'd9, 1'b1, 6'd3));
    send_frame(mk_frame(1'b1, KIND_ALT_DATA, 5'd5, 1'b1, 6'd63));
    // error frame ends the transfer as failed
    send_frame(mk_frame(1'b1, KIND_ERR, 5'd31, 1'b0, 6'd63));
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd3, 1'b1, 6'd0));
    send_frame(mk_frame(1'b1, KIND_DATA, 5'd3, 1'b1, 6'd0));
    send_frame(mk_frame(1'b1, KIND_END, 5'd0, 1'b1, 6'd0));

    tx_next = '0;
    tx_base = '0;
    beats_sent  = 0;
    while (beats_sent - noise_beats < RANDOM_BEATS) begin
      steady_phase = (beats_sent >= 400 && beats_sent < 600);
      pick = $urandom_range(99);
      if (pick < 64) begin
        send_in_order_data();
      end else if (pick < 70) begin
        f = rand_frame();
        f.header_ok = 1'b0;
        send_frame(f);
        noise_beats++;
      end else if (pick < 73) begin
        f = rand_frame();
        f.header_ok  = 1'b1;
        f.crc_ok     = 1'b1;
        f.frame_kind = KIND_END;
        f.frame_seq  = tx_next;
        send_frame(f);
        tx_next = '0;
        tx_base = '0;
      end else if (pick < 75) begin
        f = rand_frame();
        f.header_ok  = 1'b1;
        f.frame_kind = KIND_ERR;
        send_frame(f);
        tx_next = '0;
        tx_base = '0;
      end else if (pick < 87) begin
        f = rand_frame();
        f.header_ok = 1'b1;
        f.crc_ok    = 1'b0;
        if (f.frame_kind == KIND_ERR) f.frame_kind = KIND_END;
        send_frame(f);
        run_drain(1'b1);
      end else begin
        f = rand_frame();
        f.header_ok = 1'b1;
        f.crc_ok    = 1'b1;
        if (f.frame_kind == KIND_ERR) f.frame_kind = KIND_DATA;
        f.frame_seq = tx_next + SeqW'($urandom_range(1, SeqCount - 1));
        send_frame(f);
        run_drain(1'b0);
      end
    end
    steady_phase = 1'b0;
    frame_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d frame beats: %0d acks, %0d nacks, %0d payload writes,",
             frames, acks, nacks, writes);
    $display("%0d finished transfers, %0d mismatches", transfers, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
